// ----- src/wave_grid_stencil_step_unit_defines.svh -----
`ifndef WAVE_GRID_STENCIL_STEP_UNIT_DEFINES_SVH
`define WAVE_GRID_STENCIL_STEP_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WGS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wgs check failed");

// next-cycle implication, checked outside reset
`define WGS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wgs check failed");

`endif

// ----- src/wgs_pkg.sv -----
package wgs_pkg;

   localparam int GridBits  = 8;
   localparam int AddrWidth = 2 * GridBits;
   localparam int ValWidth  = 32;
   localparam int DivWidth  = 15;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] CSR_DIVISOR = 2'd0;
   localparam logic [1:0] CSR_COL     = 2'd1;
   localparam logic [1:0] CSR_ROW     = 2'd2;
   localparam logic [1:0] CSR_SIZE    = 2'd3;

   typedef struct packed {
      logic                start;
      logic [ValWidth-1:0] num;
      logic [DivWidth-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [ValWidth-1:0] quot;
   } div_rsp_type;

endpackage

// ----- src/wave_grid_stencil_step_unit.sv -----
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tuser opcode, tdata cell fields
// rsp     | out | rsp_tvalid/tready    | tdata height, velocity, done flag
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
// Write and read transactions are handled one item at a time.
// A step runs a velocity pass over each interior cell (height/velocity reads,
// a wait on the divider, one write) followed by a height pass of one read and
// one write per cell. Reset is synchronous; the grids are not
// cleared. A result held on rsp blocks the next request until taken.
`include "wave_grid_stencil_step_unit_defines.svh"

module wave_grid_stencil_step_unit
   import wgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // cell_row, cell_col, height_in, velocity_in
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // height_out, velocity_out, item_done, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_NBR  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_VWR  = 3'd4;
   localparam logic [2:0] S_HRD  = 3'd5;
   localparam logic [2:0] S_HWR  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [2:0]          nbr_ff, nbr_in;
   logic [7:0]          row_ff, row_in, col_ff, col_in;
   logic [7:0]          c0_ff, c0_in, c1_ff, c1_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [ValWidth-1:0] acc_ff, acc_in, vel_ff, vel_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ValWidth-1:0] hout_ff, hout_in, vout_ff, vout_in;
   logic [14:0]         divisor_ff;
   logic [7:0]          rcol_ff, rrow_ff;
   logic [8:0]          rsize_ff;

   logic [8:0]          lo_col, lo_row;
   logic [9:0]          hi_col, hi_row;
   logic                region_empty;
   logic [AddrWidth-1:0] cell_addr;
   logic                last_col, last_row;

   logic                h_we, v_we, h_re, v_re;
   logic [AddrWidth-1:0] h_waddr, v_waddr, h_raddr, v_raddr;
   logic [ValWidth-1:0] h_wdata, v_wdata, h_rdata, v_rdata;
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic                req_fire;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= 15'd1;
         rcol_ff    <= '0;
         rrow_ff    <= '0;
         rsize_ff   <= 9'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DIVISOR: divisor_ff <= csr_data;
            CSR_COL:     rcol_ff    <= csr_data[7:0];
            CSR_ROW:     rrow_ff    <= csr_data[7:0];
            CSR_SIZE:    rsize_ff   <= csr_data[8:0];
            default:     divisor_ff <= divisor_ff;
         endcase
      end
   end

   always_comb begin
      lo_col = {1'b0, rcol_ff} + 9'd1;
      lo_row = {1'b0, rrow_ff} + 9'd1;
      hi_col = (rsize_ff >= 9'd2) ? ({2'b0, rcol_ff} + {1'b0, rsize_ff} - 10'd2) : 10'd0;
      hi_row = (rsize_ff >= 9'd2) ? ({2'b0, rrow_ff} + {1'b0, rsize_ff} - 10'd2) : 10'd0;
      if (hi_col > 10'd254) begin
         hi_col = 10'd254;
      end
      if (hi_row > 10'd254) begin
         hi_row = 10'd254;
      end
      region_empty = ({1'b0, lo_col} > hi_col) || ({1'b0, lo_row} > hi_row);
   end

   assign cell_addr = {row_ff, col_ff};
   assign last_col  = (col_ff == c1_ff);
   assign last_row  = (row_ff == r1_ff);

   always_comb begin
      state_in     = state_ff;
      nbr_in       = nbr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      acc_in       = acc_ff;
      vel_in       = vel_ff;
      rsp_valid_in = rsp_valid_ff;
      hout_in      = hout_ff;
      vout_in      = vout_ff;
      h_we = 1'b0;
      v_we = 1'b0;
      h_re = 1'b0;
      v_re = 1'b0;
      h_waddr = cell_addr;
      v_waddr = cell_addr;
      h_raddr = cell_addr;
      v_raddr = cell_addr;
      h_wdata = h_rdata + v_rdata;
      v_wdata = vel_ff + div_rsp.quot;
      div_req.start = 1'b0;
      div_req.num   = acc_ff - {h_rdata[ValWidth-3:0], 2'b00};
      div_req.den   = divisor_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               hout_in = '0;
               vout_in = '0;
               row_in  = req_tdata[7:0];
               col_in  = req_tdata[15:8];
               priority if (req_tuser == OP_WRITE) begin
                  h_we    = 1'b1;
                  v_we    = 1'b1;
                  h_waddr = {req_tdata[7:0], req_tdata[15:8]};
                  v_waddr = {req_tdata[7:0], req_tdata[15:8]};
                  h_wdata = req_tdata[47:16];
                  v_wdata = req_tdata[79:48];
                  rsp_valid_in = 1'b1;
               end else if (req_tuser == OP_READ) begin
                  h_re    = 1'b1;
                  v_re    = 1'b1;
                  h_raddr = {req_tdata[7:0], req_tdata[15:8]};
                  v_raddr = {req_tdata[7:0], req_tdata[15:8]};
                  state_in = S_READ;
               end else if (req_tuser == OP_STEP && !region_empty) begin
                  c0_in  = lo_col[7:0];
                  c1_in  = hi_col[7:0];
                  r0_in  = lo_row[7:0];
                  r1_in  = hi_row[7:0];
                  row_in = lo_row[7:0];
                  col_in = lo_col[7:0];
                  nbr_in = '0;
                  state_in = S_NBR;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            hout_in = h_rdata;
            vout_in = v_rdata;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_NBR: begin
            nbr_in = nbr_ff + 3'd1;
            if (nbr_ff <= 3'd4) begin
               h_re = 1'b1;
               unique case (nbr_ff)
                  3'd0:    h_raddr = {row_ff, col_ff - 8'd1};
                  3'd1:    h_raddr = {row_ff, col_ff + 8'd1};
                  3'd2:    h_raddr = {row_ff - 8'd1, col_ff};
                  3'd3:    h_raddr = {row_ff + 8'd1, col_ff};
                  default: h_raddr = cell_addr;
               endcase
               v_re = (nbr_ff == 3'd4);
            end
            if (nbr_ff == 3'd0) begin
               acc_in = '0;
            end else if (nbr_ff <= 3'd4) begin
               acc_in = acc_ff + h_rdata;
            end else begin
               vel_in = v_rdata;
               div_req.start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_VWR;
            end
         end
         S_VWR: begin
            v_we   = 1'b1;
            nbr_in = '0;
            state_in = S_NBR;
            if (last_col) begin
               col_in = c0_ff;
               if (last_row) begin
                  row_in = r0_ff;
                  state_in = S_HRD;
               end else begin
                  row_in = row_ff + 8'd1;
               end
            end else begin
               col_in = col_ff + 8'd1;
            end
         end
         S_HRD: begin
            h_re = 1'b1;
            v_re = 1'b1;
            state_in = S_HWR;
         end
         S_HWR: begin
            h_we = 1'b1;
            state_in = S_HRD;
            if (last_col) begin
               col_in = c0_ff;
               if (last_row) begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  row_in = row_ff + 8'd1;
               end
            end else begin
               col_in = col_ff + 8'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         nbr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nbr_ff       <= nbr_in;
      end
      row_ff  <= row_in;
      col_ff  <= col_in;
      c0_ff   <= c0_in;
      c1_ff   <= c1_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      acc_ff  <= acc_in;
      vel_ff  <= vel_in;
      hout_ff <= hout_in;
      vout_ff <= vout_in;
   end

   wgs_ram u_height (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_en   (h_re),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   wgs_ram u_velocity (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_en   (v_re),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   wgs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, 1'b1, vout_ff, hout_ff};

   `WGS_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_ff == S_DIV)
   `WGS_ASSERT_NOW(a_rsp_only_idle, $rose(rsp_valid_ff), state_ff == S_IDLE)
   `WGS_ASSERT_NOW(a_nbr_range, state_ff == S_NBR, nbr_ff <= 3'd5)
   `WGS_ASSERT_NEXT(a_step_starts, req_fire && req_tuser == OP_STEP && !region_empty,
                    state_ff == S_NBR && nbr_ff == 3'd0)

endmodule

// ----- src/wgs_ram.sv -----
module wgs_ram
   import wgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [ValWidth-1:0]  wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [ValWidth-1:0]  rd_data
);

   logic [ValWidth-1:0] mem [0:(1<<AddrWidth)-1];
   logic [ValWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/wgs_div.sv -----
module wgs_div
   import wgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [DivWidth:0]   rem_ff, rem_in;
   logic [ValWidth-1:0] mag_ff, mag_in;
   logic [DivWidth-1:0] den_ff, den_in;
   logic [DivWidth:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      mag_in  = mag_ff;
      den_in  = den_ff;
      trial   = {rem_ff[DivWidth-1:0], mag_ff[ValWidth-1]};
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.num[ValWidth-1];
         mag_in  = req.num[ValWidth-1] ? (~req.num + 1'b1) : req.num;
         rem_in  = '0;
         cnt_in  = '0;
         den_in  = (req.den == '0) ? DivWidth'(1) : req.den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            mag_in = {mag_ff[ValWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[ValWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(ValWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = neg_ff ? (~mag_ff + 1'b1) : mag_ff;

endmodule
